// ===== rtl/core/ors_pkg.sv =====
// Shared types and constants for the 1-Wire ROM search engine.
package ors_pkg;

  localparam int unsigned SerialBits = 64;
  localparam int unsigned BitIdxW    = $clog2(SerialBits);
  localparam int unsigned MarkW      = BitIdxW + 1;

  localparam logic [7:0]       CrcPoly    = 8'h8C;
  localparam logic [7:0]       CmdReset   = 8'hF0;
  localparam logic [MarkW-1:0] NoMark     = '1;
  localparam logic [BitIdxW-1:0] LastBit  = BitIdxW'(SerialBits - 1);

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_TRIPLET = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_BUS_ERR = 2'd3
  } ors_kind_e;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    RK_TRIPLET = 2'd0,
    RK_FOUND   = 2'd1,
    RK_DONE    = 2'd2,
    RK_ERROR   = 2'd3
  } ors_rkind_e;

  typedef struct packed {
    ors_rkind_e             kind;
    logic                   send;
    logic [7:0]             cmd;
    logic                   dir;
    logic [BitIdxW-1:0]     idx;
    logic [SerialBits-1:0]  rom;
  } ors_result_t;

endpackage

// ===== rtl/core/ors_core.sv =====
// Search state, CRC and per-request result logic of the ROM search engine.
module ors_core
  import ors_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i,
  input  logic          fire_i,
  input  logic [1:0]    kind_i,
  input  logic          first_read_i,
  input  logic          second_read_i,
  input  logic          taken_dir_i,
  output logic          res_valid_o,
  output ors_result_t   res_o
);

  logic [7:0]            cmd_q;
  logic [SerialBits-1:0] serial_q, serial_d;
  logic [MarkW-1:0]      pd_q, pd_d;
  logic                  finished_q, finished_d;
  logic [BitIdxW-1:0]    bit_pos_q, bit_pos_d;
  logic [MarkW-1:0]      pzm_q, pzm_d;
  logic [7:0]            crc_q, crc_d;
  logic                  active_q, active_d;

  logic [BitIdxW-1:0]    next_pos;
  logic [7:0]            crc_step;
  logic                  crc_fb;
  ors_kind_e             kind;

  // Preferred direction for bit b against the last discrepancy
  function automatic logic pick_dir(input logic [BitIdxW-1:0] b,
                                    input logic [MarkW-1:0] pd,
                                    input logic [SerialBits-1:0] ser);
    logic neg;
    neg = pd[MarkW-1];
    if (!neg && (b < pd[BitIdxW-1:0])) begin
      return ser[b];
    end
    return !neg && (b == pd[BitIdxW-1:0]);
  endfunction

  assign kind     = ors_kind_e'(kind_i);
  assign next_pos = bit_pos_q + BitIdxW'(1);
  assign crc_fb   = crc_q[0] ^ taken_dir_i;
  assign crc_step = (crc_q >> 1) ^ (crc_fb ? CrcPoly : 8'h00);

  // Compute next state and the result of the request
  always_comb begin
    serial_d    = serial_q;
    pd_d        = pd_q;
    finished_d  = finished_q;
    bit_pos_d   = bit_pos_q;
    pzm_d       = pzm_q;
    crc_d       = crc_q;
    active_d    = active_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i) begin
      case (kind)
        KIND_START: begin
          res_valid_o = 1'b1;
          if (finished_q) begin
            active_d   = 1'b0;
            res_o.kind = RK_DONE;
          end else begin
            active_d   = 1'b1;
            bit_pos_d  = '0;
            pzm_d      = NoMark;
            crc_d      = '0;
            res_o.kind = RK_TRIPLET;
            res_o.send = 1'b1;
            res_o.cmd  = cmd_q;
            res_o.dir  = pick_dir('0, pd_q, serial_q);
          end
        end
        KIND_CLEAR: begin
          pd_d       = NoMark;
          finished_d = 1'b0;
          active_d   = 1'b0;
        end
        KIND_BUS_ERR: begin
          active_d    = 1'b0;
          res_valid_o = 1'b1;
          res_o.kind  = RK_ERROR;
        end
        KIND_TRIPLET: begin
          if (active_q) begin
            res_valid_o = 1'b1;
            if (first_read_i && second_read_i) begin
              // no device answered
              finished_d = 1'b1;
              active_d   = 1'b0;
              res_o.kind = RK_DONE;
            end else begin
              if (!first_read_i && !second_read_i && !taken_dir_i) begin
                pzm_d = {1'b0, bit_pos_q};
              end
              serial_d[bit_pos_q] = taken_dir_i;
              crc_d = crc_step;
              if (bit_pos_q == LastBit) begin
                active_d = 1'b0;
                if ((crc_step != 8'h00) || (serial_d[7:0] == 8'h00)) begin
                  res_o.kind = RK_ERROR;
                end else begin
                  pd_d       = pzm_d;
                  finished_d = pzm_d[MarkW-1];
                  res_o.kind = RK_FOUND;
                  res_o.rom  = serial_d;
                end
              end else begin
                bit_pos_d  = next_pos;
                res_o.kind = RK_TRIPLET;
                res_o.dir  = pick_dir(next_pos, pd_q, serial_d);
                res_o.idx  = next_pos;
              end
            end
          end
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  // Hold search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q      <= CmdReset;
      serial_q   <= '0;
      pd_q       <= NoMark;
      finished_q <= 1'b0;
      bit_pos_q  <= '0;
      pzm_q      <= NoMark;
      crc_q      <= '0;
      active_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cmd_q <= cfg_data_i;
      end
      serial_q   <= serial_d;
      pd_q       <= pd_d;
      finished_q <= finished_d;
      bit_pos_q  <= bit_pos_d;
      pzm_q      <= pzm_d;
      crc_q      <= crc_d;
      active_q   <= active_d;
    end
  end

`ifndef SYNTHESIS
  // A mid-pass triplet request advances the bit position by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (kind == KIND_TRIPLET) && active_q && !(first_read_i && second_read_i)
     && (bit_pos_q != LastBit))
    |=> (bit_pos_q == BitIdxW'($past(bit_pos_q) + 1'b1)))
    else $error("bit position did not advance");

  // A start after the last device answers search done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (kind == KIND_START) && finished_q) |-> (res_o.kind == RK_DONE))
    else $error("start after finished search did not report done");

  // A found device never has a zero family code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == RK_FOUND)) |-> (res_o.rom[7:0] != 8'h00))
    else $error("found device with zero family code");

  // The command byte is only sent with the first triplet of a pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.send) |-> ((kind == KIND_START) && (res_o.kind == RK_TRIPLET)))
    else $error("command byte outside pass start");
`endif

endmodule

// ===== rtl/core/ors_out_reg.sv =====
// Result holding register between the search logic and the output channel.
module ors_out_reg
  import ors_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  ors_result_t res_i,
  input  logic        out_ready_i,
  output logic        space_o,
  output logic        out_valid_o,
  output ors_result_t res_o
);

  logic        valid_q, valid_d;
  ors_result_t res_q;

  // Take a new result when empty or when the held one leaves this cycle
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until taken
  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/onewire_rom_search_engine.sv =====
// Top level: 1-Wire ROM search engine, at most one result per request.
// A result is presented in the cycle after its request is accepted.
// Requests are accepted one per cycle while the result register has space; it frees in the cycle it is taken.
// Requests that produce no result: clear history, and a triplet with no open pass.
// Reset (async, active low): no pass open, no prior discrepancy, search not finished,
// serial and CRC cleared, search command 0xF0, output channel empty.
module onewire_rom_search_engine
  import ors_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic        first_read_i,
  input  logic        second_read_i,
  input  logic        taken_dir_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic        send_command_o,
  output logic [7:0]  command_byte_o,
  output logic        direction_o,
  output logic [5:0]  bit_index_o,
  output logic [63:0] rom_id_o
);

  logic        space;
  logic        fire;
  logic        res_valid;
  ors_result_t res;
  ors_result_t out_res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign fire        = in_valid_i && space;

  ors_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .fire_i        (fire),
    .kind_i        (kind_i),
    .first_read_i  (first_read_i),
    .second_read_i (second_read_i),
    .taken_dir_i   (taken_dir_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ors_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  // Unpack the result onto the output ports
  assign result_kind_o  = out_res.kind;
  assign send_command_o = out_res.send;
  assign command_byte_o = out_res.cmd;
  assign direction_o    = out_res.dir;
  assign bit_index_o    = out_res.idx;
  assign rom_id_o       = out_res.rom;

endmodule
